// ===== hdl/fenced_ring_allocator_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the fenced ring allocator.
// Both macros sample on the rising clock edge and are disabled during reset.
// ----------------------------------------------------------------------------
`ifndef FENCED_RING_ALLOCATOR_CORE_ASSERT_SVH
`define FENCED_RING_ALLOCATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FRA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FRA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/fra_pkg.sv =====
// ----------------------------------------------------------------------------
// fra_pkg
// Widths and codes shared by the fenced ring allocator and its channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fra_pkg;

    localparam int KIND_W  = 2;
    localparam int RING_W  = 21;   // ring size, request and byte counts
    localparam int OFS_W   = 20;   // reported offset
    localparam int FENCE_W = 64;
    localparam int STAT_W  = 3;
    localparam int ALIGN_W = 4;
    localparam int CFG_IDX_W = 1;
    localparam int DW      = RING_W + 1;  // datapath of the shared adder

    typedef logic [KIND_W-1:0] kind_t;
    typedef logic [STAT_W-1:0] status_t;

    localparam kind_t KIND_ALLOC  = 2'd0;
    localparam kind_t KIND_COMMIT = 2'd1;
    localparam kind_t KIND_FREE   = 2'd2;
    localparam kind_t KIND_RESET  = 2'd3;

    localparam status_t STAT_OK    = 3'd0;
    localparam status_t STAT_SIZE  = 3'd1;
    localparam status_t STAT_ROOM  = 3'd2;
    localparam status_t STAT_FULL  = 3'd3;
    localparam status_t STAT_FENCE = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_RING_BYTES  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_SHIFT = 1'd1;

    localparam logic [RING_W-1:0]  RING_BYTES_RST  = 21'd1048576;
    localparam logic [ALIGN_W-1:0] ALIGN_SHIFT_RST = 4'd8;

endpackage

`default_nettype wire

// ===== hdl/fra_ifs.sv =====
// ----------------------------------------------------------------------------
// fra channel interfaces
// Command and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface fra_cmd_if
    import fra_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [RING_W-1:0]   request_bytes;
    logic [FENCE_W-1:0]  fence;

    modport source (output valid, kind, request_bytes, fence, input ready);
    modport sink   (input valid, kind, request_bytes, fence, output ready);
endinterface

interface fra_rsp_if
    import fra_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STAT_W-1:0]   status;
    logic [OFS_W-1:0]    offset;
    logic [RING_W-1:0]   used_bytes;

    modport source (output valid, status, offset, used_bytes, input ready);
    modport sink   (input valid, status, offset, used_bytes, output ready);
endinterface

`default_nettype wire

// ===== hdl/fenced_ring_allocator_core.sv =====
// ----------------------------------------------------------------------------
// fenced_ring_allocator_core
// Aligned allocation from a circular byte region with fence-based retirement.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one command per transfer: allocate, commit, free or reset.
//   rsp returns exactly one result per command: status, offset, used bytes.
//   cfg_we/cfg_index/cfg_data write the ring size (index 0) and the alignment
//   shift (index 1); write them only while no command is in flight.
//   Commands run one at a time on a single shared adder/subtractor, and
//   cmd.ready is high only while the sequencer waits for a command.
//   Allocate runs its checks in steps on the adder, commit stamps each pending
//   reservation in turn, and free retires reservations in order, each with a
//   22-step remainder on the adder (none when the ring size is 0). The
//   sequencer returns to idle after loading the result and takes the next
//   command from there.
//   The result sits in an output register, so a new command is taken while
//   rsp is stalled; the sequencer holds in its final step only if a second
//   result is ready before the first one has been taken.
//   Reset clears all pointers and counters and loads the register defaults;
//   the reservation stores are not cleared, each entry is written by an
//   allocate before any free reads it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "fenced_ring_allocator_core_assert.svh"

module fenced_ring_allocator_core
    import fra_pkg::*;
#(
    parameter int ADDR_BITS   = 20,
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [RING_W-1:0]     cfg_data,
    fra_cmd_if.sink               cmd,
    fra_rsp_if.source             rsp
);

    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int MW = $clog2(DW);
    localparam int CAP_SHIFT = (ADDR_BITS >= RING_W) ? RING_W : ADDR_BITS;
    localparam logic [RING_W:0]  RING_CAP  = (RING_W + 1)'(64'd1 << CAP_SHIFT);
    localparam logic [QW-1:0]    LAST_SLOT = QW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0]    FULL_FILL = CW'(QUEUE_DEPTH);

    typedef enum logic [4:0] {
        S_IDLE,
        S_A_ROUND,
        S_A_FIT,
        S_A_AVAIL,
        S_A_ROOM,
        S_A_ORDER,
        S_A_END,
        S_A_PLACE,
        S_A_PAD,
        S_A_HEADCK,
        S_A_PADSUM,
        S_A_PADROOM,
        S_A_GRANT,
        S_C_START,
        S_C_WALK,
        S_R_READ,
        S_R_CHECK,
        S_R_ADD,
        S_R_MOD,
        S_R_USED,
        S_R_FINAL,
        S_DONE
    } state_t;

    state_t                state_reg;

    logic [RING_W-1:0]     ring_bytes_reg;
    logic [ALIGN_W-1:0]    align_shift_reg;

    logic [RING_W-1:0]     head_reg;
    logic [RING_W-1:0]     tail_reg;
    logic [RING_W-1:0]     used_reg;
    logic [CW-1:0]         pending_reg;
    logic [CW-1:0]         fill_reg;
    logic [QW-1:0]         front_reg;
    logic [QW-1:0]         back_reg;

    logic [RING_W-1:0]     req_reg;
    logic [FENCE_W-1:0]    fence_reg;
    logic [DW-1:0]         size_reg;
    logic [DW-1:0]         avail_reg;
    logic [DW-1:0]         sum_reg;
    logic [DW-1:0]         charge_reg;
    logic                  ge_reg;
    logic [RING_W-1:0]     at_reg;
    logic [RING_W-1:0]     new_tail_reg;
    logic [QW-1:0]         walk_idx_reg;
    logic [CW-1:0]         walk_cnt_reg;
    logic [DW-1:0]         div_reg;
    logic [DW-1:0]         rem_reg;
    logic [MW-1:0]         mod_cnt_reg;
    status_t               status_reg;

    logic                  rsp_valid_reg;
    status_t               rsp_status_reg;
    logic [OFS_W-1:0]      rsp_offset_reg;
    logic [RING_W-1:0]     rsp_used_reg;

    logic [FENCE_W-1:0]    fence_mem [QUEUE_DEPTH];
    logic [RING_W-1:0]     size_mem  [QUEUE_DEPTH];
    logic [FENCE_W-1:0]    rd_fence_reg;
    logic [RING_W-1:0]     rd_size_reg;

    logic [RING_W-1:0]     total;
    logic [DW-1:0]         mask;
    logic [DW-1:0]         unit_a;
    logic [DW-1:0]         unit_b;
    logic                  unit_sub;
    logic [DW-1:0]         unit_y;
    logic                  unit_c;
    logic                  mem_we;
    logic                  mem_size_we;
    logic [QW-1:0]         mem_addr;
    logic [FENCE_W-1:0]    mem_fence_wd;
    logic                  queue_full;

    // A ring larger than the address space behaves as the address space.
    assign total = ({1'b0, ring_bytes_reg} > RING_CAP) ? RING_CAP[RING_W-1:0]
                                                      : ring_bytes_reg;
    assign mask       = (DW'(1) << align_shift_reg) - DW'(1);
    assign queue_full = (fill_reg >= FULL_FILL);

    // Shared adder/subtractor. On a subtract, the carry is set when a >= b.
    always_comb
    begin
        unit_a   = '0;
        unit_b   = '0;
        unit_sub = 1'b1;
        case (state_reg)
            S_A_ROUND:
            begin
                unit_a   = DW'(req_reg);
                unit_b   = mask;
                unit_sub = 1'b0;
            end
            S_A_FIT:
            begin
                unit_a = DW'(total);
                unit_b = size_reg;
            end
            S_A_AVAIL:
            begin
                unit_a = DW'(total);
                unit_b = DW'(used_reg);
            end
            S_A_ROOM:
            begin
                unit_a = avail_reg;
                unit_b = size_reg;
            end
            S_A_ORDER:
            begin
                unit_a = DW'(tail_reg);
                unit_b = DW'(head_reg);
            end
            S_A_END:
            begin
                unit_a   = DW'(tail_reg);
                unit_b   = size_reg;
                unit_sub = 1'b0;
            end
            S_A_PLACE:
            begin
                unit_a = ge_reg ? DW'(total) : DW'(head_reg);
                unit_b = sum_reg;
            end
            S_A_PAD:
            begin
                unit_a = DW'(total);
                unit_b = DW'(tail_reg);
            end
            S_A_HEADCK:
            begin
                unit_a = DW'(head_reg);
                unit_b = size_reg;
            end
            S_A_PADSUM:
            begin
                unit_a   = sum_reg;
                unit_b   = size_reg;
                unit_sub = 1'b0;
            end
            S_A_PADROOM:
            begin
                unit_a = avail_reg;
                unit_b = charge_reg;
            end
            S_A_GRANT:
            begin
                unit_a   = DW'(used_reg);
                unit_b   = charge_reg;
                unit_sub = 1'b0;
            end
            S_R_ADD:
            begin
                unit_a   = DW'(head_reg);
                unit_b   = DW'(rd_size_reg);
                unit_sub = 1'b0;
            end
            S_R_MOD:
            begin
                unit_a = {rem_reg[DW-2:0], div_reg[DW-1]};
                unit_b = DW'(total);
            end
            S_R_USED:
            begin
                unit_a = DW'(used_reg);
                unit_b = DW'(rd_size_reg);
            end
            default:
            begin
                unit_a   = '0;
                unit_b   = '0;
                unit_sub = 1'b1;
            end
        endcase
    end

    assign {unit_c, unit_y} = {1'b0, unit_a} + {1'b0, (unit_sub ? ~unit_b : unit_b)}
                            + (DW + 1)'(unit_sub);

    // Reservation stores: one write port, read at the queue front.
    assign mem_we       = (state_reg == S_A_GRANT) ||
                          ((state_reg == S_C_WALK) && (walk_cnt_reg != '0));
    assign mem_size_we  = (state_reg == S_A_GRANT);
    assign mem_addr     = (state_reg == S_A_GRANT) ? back_reg : walk_idx_reg;
    assign mem_fence_wd = (state_reg == S_A_GRANT) ? '0 : fence_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            fence_mem[mem_addr] <= mem_fence_wd;
        end
        if (mem_size_we)
        begin
            size_mem[mem_addr] <= charge_reg[RING_W-1:0];
        end
        rd_fence_reg <= fence_mem[front_reg];
        rd_size_reg  <= size_mem[front_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_bytes_reg  <= RING_BYTES_RST;
            align_shift_reg <= ALIGN_SHIFT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RING_BYTES:  ring_bytes_reg  <= cfg_data;
                CFG_ALIGN_SHIFT: align_shift_reg <= cfg_data[ALIGN_W-1:0];
                default:         ring_bytes_reg  <= ring_bytes_reg;
            endcase
        end
    end

    assign cmd.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = rsp_valid_reg;
    assign rsp.status     = rsp_status_reg;
    assign rsp.offset     = rsp_offset_reg;
    assign rsp.used_bytes = rsp_used_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            tail_reg       <= '0;
            used_reg       <= '0;
            pending_reg    <= '0;
            fill_reg       <= '0;
            front_reg      <= '0;
            back_reg       <= '0;
            req_reg        <= '0;
            fence_reg      <= '0;
            size_reg       <= '0;
            avail_reg      <= '0;
            sum_reg        <= '0;
            charge_reg     <= '0;
            ge_reg         <= 1'b0;
            at_reg         <= '0;
            new_tail_reg   <= '0;
            walk_idx_reg   <= '0;
            walk_cnt_reg   <= '0;
            div_reg        <= '0;
            rem_reg        <= '0;
            mod_cnt_reg    <= '0;
            status_reg     <= STAT_OK;
            rsp_valid_reg  <= 1'b0;
            rsp_status_reg <= STAT_OK;
            rsp_offset_reg <= '0;
            rsp_used_reg   <= '0;
        end
        else
        begin
            // In the final step the output register is handled there.
            if (rsp_valid_reg && rsp.ready && (state_reg != S_DONE))
            begin
                rsp_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (cmd.valid)
                    begin
                        req_reg    <= cmd.request_bytes;
                        fence_reg  <= cmd.fence;
                        at_reg     <= '0;
                        status_reg <= STAT_OK;
                        case (cmd.kind)
                            KIND_ALLOC:  state_reg <= S_A_ROUND;
                            KIND_COMMIT: state_reg <= S_C_START;
                            KIND_FREE:   state_reg <= S_R_READ;
                            default:
                            begin
                                head_reg    <= '0;
                                tail_reg    <= '0;
                                used_reg    <= '0;
                                pending_reg <= '0;
                                fill_reg    <= '0;
                                front_reg   <= '0;
                                back_reg    <= '0;
                                state_reg   <= S_DONE;
                            end
                        endcase
                    end
                end

                S_A_ROUND:
                begin
                    size_reg  <= unit_y & ~mask;
                    state_reg <= S_A_FIT;
                end
                S_A_FIT:
                begin
                    if ((size_reg == '0) || !unit_c)
                    begin
                        status_reg <= STAT_SIZE;
                        state_reg  <= S_DONE;
                    end
                    else if (queue_full)
                    begin
                        status_reg <= STAT_FULL;
                        state_reg  <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_A_AVAIL;
                    end
                end
                S_A_AVAIL:
                begin
                    // Free space saturates at zero if the ring has shrunk.
                    avail_reg <= unit_c ? unit_y : '0;
                    state_reg <= S_A_ROOM;
                end
                S_A_ROOM:
                begin
                    if (!unit_c)
                    begin
                        status_reg <= STAT_ROOM;
                        state_reg  <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_A_ORDER;
                    end
                end
                S_A_ORDER:
                begin
                    ge_reg    <= unit_c;
                    state_reg <= S_A_END;
                end
                S_A_END:
                begin
                    sum_reg   <= unit_y;
                    state_reg <= S_A_PLACE;
                end
                S_A_PLACE:
                begin
                    charge_reg <= size_reg;
                    at_reg     <= tail_reg;
                    if (unit_c)
                    begin
                        // Landing exactly on the end of the ring wraps the tail to 0.
                        if (ge_reg && (sum_reg == DW'(total)))
                        begin
                            new_tail_reg <= '0;
                        end
                        else
                        begin
                            new_tail_reg <= sum_reg[RING_W-1:0];
                        end
                        state_reg <= S_A_GRANT;
                    end
                    else if (ge_reg)
                    begin
                        state_reg <= S_A_PAD;
                    end
                    else
                    begin
                        status_reg <= STAT_ROOM;
                        state_reg  <= S_DONE;
                    end
                end
                S_A_PAD:
                begin
                    sum_reg   <= unit_c ? unit_y : '0;
                    state_reg <= S_A_HEADCK;
                end
                S_A_HEADCK:
                begin
                    if (!unit_c)
                    begin
                        status_reg <= STAT_ROOM;
                        state_reg  <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_A_PADSUM;
                    end
                end
                S_A_PADSUM:
                begin
                    charge_reg <= unit_y;
                    state_reg  <= S_A_PADROOM;
                end
                S_A_PADROOM:
                begin
                    if (!unit_c)
                    begin
                        status_reg <= STAT_ROOM;
                        state_reg  <= S_DONE;
                    end
                    else
                    begin
                        at_reg       <= '0;
                        new_tail_reg <= size_reg[RING_W-1:0];
                        state_reg    <= S_A_GRANT;
                    end
                end
                S_A_GRANT:
                begin
                    used_reg    <= unit_y[RING_W-1:0];
                    tail_reg    <= new_tail_reg;
                    back_reg    <= (back_reg == LAST_SLOT) ? '0 : back_reg + QW'(1);
                    fill_reg    <= fill_reg + CW'(1);
                    pending_reg <= pending_reg + CW'(1);
                    state_reg   <= S_DONE;
                end

                S_C_START:
                begin
                    if (pending_reg == '0)
                    begin
                        state_reg <= S_DONE;
                    end
                    else if (fence_reg == '0)
                    begin
                        status_reg <= STAT_FENCE;
                        state_reg  <= S_DONE;
                    end
                    else
                    begin
                        // Walk backward from the newest reservation.
                        walk_idx_reg <= (back_reg == '0) ? LAST_SLOT : back_reg - QW'(1);
                        walk_cnt_reg <= (pending_reg < fill_reg) ? pending_reg : fill_reg;
                        state_reg    <= S_C_WALK;
                    end
                end
                S_C_WALK:
                begin
                    if (walk_cnt_reg == '0)
                    begin
                        pending_reg <= '0;
                        state_reg   <= S_DONE;
                    end
                    else
                    begin
                        walk_idx_reg <= (walk_idx_reg == '0) ? LAST_SLOT
                                                             : walk_idx_reg - QW'(1);
                        walk_cnt_reg <= walk_cnt_reg - CW'(1);
                    end
                end

                S_R_READ:
                begin
                    // The read data register follows the front in this cycle.
                    state_reg <= (fill_reg == '0) ? S_R_FINAL : S_R_CHECK;
                end
                S_R_CHECK:
                begin
                    if ((rd_fence_reg == '0) || (rd_fence_reg > fence_reg))
                    begin
                        state_reg <= S_R_FINAL;
                    end
                    else
                    begin
                        state_reg <= S_R_ADD;
                    end
                end
                S_R_ADD:
                begin
                    div_reg     <= unit_y;
                    rem_reg     <= '0;
                    mod_cnt_reg <= MW'(DW - 1);
                    if (total == '0)
                    begin
                        head_reg  <= '0;
                        state_reg <= S_R_USED;
                    end
                    else
                    begin
                        state_reg <= S_R_MOD;
                    end
                end
                S_R_MOD:
                begin
                    // Restoring remainder, one dividend bit per cycle.
                    div_reg <= {div_reg[DW-2:0], 1'b0};
                    rem_reg <= unit_c ? unit_y : unit_a;
                    if (mod_cnt_reg == '0)
                    begin
                        head_reg  <= unit_c ? unit_y[RING_W-1:0] : unit_a[RING_W-1:0];
                        state_reg <= S_R_USED;
                    end
                    else
                    begin
                        mod_cnt_reg <= mod_cnt_reg - MW'(1);
                    end
                end
                S_R_USED:
                begin
                    used_reg  <= unit_c ? unit_y[RING_W-1:0] : '0;
                    front_reg <= (front_reg == LAST_SLOT) ? '0 : front_reg + QW'(1);
                    fill_reg  <= fill_reg - CW'(1);
                    state_reg <= S_R_READ;
                end
                S_R_FINAL:
                begin
                    if (fill_reg == '0)
                    begin
                        head_reg <= '0;
                        tail_reg <= '0;
                        used_reg <= '0;
                    end
                    state_reg <= S_DONE;
                end

                S_DONE:
                begin
                    if (!rsp_valid_reg || rsp.ready)
                    begin
                        rsp_valid_reg  <= 1'b1;
                        rsp_status_reg <= status_reg;
                        rsp_offset_reg <= (status_reg == STAT_OK) ? at_reg[OFS_W-1:0] : '0;
                        rsp_used_reg   <= used_reg;
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `FRA_ASSERT_SAME(a_pending_le_fill, clk, rst_n, 1'b1, pending_reg <= fill_reg, "pending reservations exceed queue fill")
    `FRA_ASSERT_SAME(a_empty_is_clear, clk, rst_n, (state_reg == S_IDLE) && (fill_reg == '0), (used_reg == '0) && (head_reg == '0) && (tail_reg == '0), "empty queue with live ring pointers")
    `FRA_ASSERT_NEXT(a_grant_fills, clk, rst_n, (state_reg == S_A_GRANT), (fill_reg != '0) && (state_reg == S_DONE), "grant did not enqueue a reservation")

endmodule

`default_nettype wire
